>>> hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, codes and types for the allocator controller and datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int MAX_BLOCKS     = 64;
   localparam int HEAP_BYTES_MAX = 1048576;
   localparam int IDX_W          = $clog2(MAX_BLOCKS);
   localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
   localparam int PAY_W          = $clog2(HEAP_BYTES_MAX + 1);
   localparam int SIZE_W         = 21;
   localparam int ADDR_W         = 32;
   localparam int HDR_W          = 7;
   localparam int HDRR_W         = HDR_W + 1;
   localparam int OP_W           = 2;
   localparam int STS_W          = 2;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 32;
   localparam int HEAP_W         = 21;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

   localparam logic [STS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STS_W-1:0] STS_ZERO_SIZE = 2'd1;
   localparam logic [STS_W-1:0] STS_NO_FIT    = 2'd2;
   localparam logic [STS_W-1:0] STS_BAD_ADDR  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BYTES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 2'd2;

   typedef struct packed {
      logic [PAY_W-1:0] offset;
      logic [PAY_W-1:0] payload;
      logic             is_free;
   } blk_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_INIT,
      CMD_RES_ZERO,
      CMD_RES_OK,
      CMD_SCAN_START,
      CMD_READ,
      CMD_SCAN_NEXT,
      CMD_SCAN_MISS,
      CMD_TAKE_WHOLE,
      CMD_SPLIT_START,
      CMD_SHIFT_READ,
      CMD_SHIFT_WRITE,
      CMD_SPLIT_NEW,
      CMD_SPLIT_OLD,
      CMD_FREE_START,
      CMD_MERGE_STEP,
      CMD_MERGE_END
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            req_zero;
      logic            scan_end;
      logic            hit;
      logic            split_ok;
      logic            shift_done;
   } dp_status_type;

   function automatic logic [PAY_W-1:0] sat_heap(input logic [PAY_W+1:0] v);
      logic [PAY_W-1:0] r;
      if (v > (PAY_W+2)'(HEAP_BYTES_MAX)) begin
         r = PAY_W'(HEAP_BYTES_MAX);
      end else begin
         r = v[PAY_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator controller
// Sequences scan, split, shift and merge passes over the block table.
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ffha_pkg::dp_status_type dp_sts,
   output ffha_pkg::dp_cmd_type   dp_cmd
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SPLIT_NEW,
      S_SPLIT_OLD,
      S_MRG_RD,
      S_MRG_ACC,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      dp_cmd   = ffha_pkg::CMD_NONE;
      case (state_ff)
         S_INIT: begin
            dp_cmd   = ffha_pkg::CMD_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd   = ffha_pkg::CMD_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (dp_sts.op)
               ffha_pkg::OP_ALLOC: begin
                  if (dp_sts.req_zero) begin
                     dp_cmd   = ffha_pkg::CMD_RES_ZERO;
                     state_in = S_OUT;
                  end else begin
                     dp_cmd   = ffha_pkg::CMD_SCAN_START;
                     state_in = S_SCAN_RD;
                  end
               end
               ffha_pkg::OP_FREE: begin
                  dp_cmd   = ffha_pkg::CMD_SCAN_START;
                  state_in = S_SCAN_RD;
               end
               ffha_pkg::OP_INIT: begin
                  dp_cmd   = ffha_pkg::CMD_INIT;
                  state_in = S_OUT;
               end
               default: begin
                  dp_cmd   = ffha_pkg::CMD_RES_OK;
                  state_in = S_OUT;
               end
            endcase
         end
         S_SCAN_RD: begin
            if (dp_sts.scan_end) begin
               dp_cmd   = ffha_pkg::CMD_SCAN_MISS;
               state_in = S_OUT;
            end else begin
               dp_cmd   = ffha_pkg::CMD_READ;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (!dp_sts.hit) begin
               dp_cmd   = ffha_pkg::CMD_SCAN_NEXT;
               state_in = S_SCAN_RD;
            end else if (dp_sts.op == ffha_pkg::OP_FREE) begin
               dp_cmd   = ffha_pkg::CMD_FREE_START;
               state_in = S_MRG_RD;
            end else if (dp_sts.split_ok) begin
               dp_cmd   = ffha_pkg::CMD_SPLIT_START;
               state_in = S_SHIFT_RD;
            end else begin
               dp_cmd   = ffha_pkg::CMD_TAKE_WHOLE;
               state_in = S_OUT;
            end
         end
         S_SHIFT_RD: begin
            if (dp_sts.shift_done) begin
               state_in = S_SPLIT_NEW;
            end else begin
               dp_cmd   = ffha_pkg::CMD_SHIFT_READ;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            dp_cmd   = ffha_pkg::CMD_SHIFT_WRITE;
            state_in = S_SHIFT_RD;
         end
         S_SPLIT_NEW: begin
            dp_cmd   = ffha_pkg::CMD_SPLIT_NEW;
            state_in = S_SPLIT_OLD;
         end
         S_SPLIT_OLD: begin
            dp_cmd   = ffha_pkg::CMD_SPLIT_OLD;
            state_in = S_OUT;
         end
         S_MRG_RD: begin
            if (dp_sts.scan_end) begin
               dp_cmd   = ffha_pkg::CMD_MERGE_END;
               state_in = S_OUT;
            end else begin
               dp_cmd   = ffha_pkg::CMD_READ;
               state_in = S_MRG_ACC;
            end
         end
         S_MRG_ACC: begin
            dp_cmd   = ffha_pkg::CMD_MERGE_STEP;
            state_in = S_MRG_RD;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

>>> hw/rtl/ffha_datapath.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator datapath
// Block table memory, configuration registers and the size and address math.
// ----------------------------------------------------------------------------
module ffha_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffha_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [ffha_pkg::OP_W-1:0]         req_op,
   input  logic [ffha_pkg::SIZE_W-1:0]       req_size,
   input  logic [ffha_pkg::ADDR_W-1:0]       req_release_address,
   input  ffha_pkg::dp_cmd_type              dp_cmd,
   output ffha_pkg::dp_status_type           dp_sts,
   output logic [ffha_pkg::STS_W-1:0]        res_status,
   output logic [ffha_pkg::ADDR_W-1:0]       res_address
);

   localparam int PW = ffha_pkg::PAY_W;
   localparam int CW = ffha_pkg::CNT_W;
   localparam int IW = ffha_pkg::IDX_W;

   ffha_pkg::blk_type mem [ffha_pkg::MAX_BLOCKS];

   logic [ffha_pkg::ADDR_W-1:0]  base_ff;
   logic [ffha_pkg::HEAP_W-1:0]  bytes_ff;
   logic [ffha_pkg::HDR_W-1:0]   hdr_ff;
   logic [ffha_pkg::OP_W-1:0]    op_ff, op_in;
   logic [ffha_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [ffha_pkg::ADDR_W-1:0]  rel_ff, rel_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [IW-1:0]                k_ff, k_in;
   logic [IW-1:0]                w_ff, w_in;
   ffha_pkg::blk_type            rd_ff;
   ffha_pkg::blk_type            hold_ff, hold_in;
   ffha_pkg::blk_type            pend_ff, pend_in;
   logic [ffha_pkg::STS_W-1:0]   sts_ff, sts_in;
   logic [ffha_pkg::ADDR_W-1:0]  addr_ff, addr_in;

   logic                         we;
   logic [IW-1:0]                wa;
   ffha_pkg::blk_type            wd;
   logic                         re;
   logic [IW-1:0]                ra;

   logic [ffha_pkg::HDRR_W-1:0]  hsum;
   logic [ffha_pkg::HDRR_W-1:0]  h;
   logic [PW-1:0]                total;
   logic [PW-1:0]                init_pay;
   logic [ffha_pkg::SIZE_W:0]    rsize;
   logic [PW+1:0]                need;
   logic                         hit_alloc;
   logic                         hit_free;
   logic [ffha_pkg::ADDR_W-1:0]  rd_addr;
   logic [ffha_pkg::ADDR_W-1:0]  hold_addr;
   logic [PW-1:0]                new_off;
   logic [PW+1:0]                new_pay_w;
   logic [CW-1:0]                idx_m1;
   ffha_pkg::blk_type            e_in;
   logic                         join_ok;
   logic [PW-1:0]                join_pay;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         bytes_ff <= ffha_pkg::HEAP_W'(ffha_pkg::HEAP_BYTES_MAX);
         hdr_ff   <= ffha_pkg::HDR_W'(24);
      end else if (csr_we) begin
         case (csr_index)
            ffha_pkg::CSR_HEAP_BASE:    base_ff  <= csr_wdata;
            ffha_pkg::CSR_HEAP_BYTES:   bytes_ff <= csr_wdata[ffha_pkg::HEAP_W-1:0];
            ffha_pkg::CSR_HEADER_BYTES: hdr_ff   <= csr_wdata[ffha_pkg::HDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign hsum = {1'b0, hdr_ff} + ffha_pkg::HDRR_W'(7);
   assign h    = {hsum[ffha_pkg::HDRR_W-1:3], 3'b000};

   assign total    = (bytes_ff > ffha_pkg::HEAP_W'(ffha_pkg::HEAP_BYTES_MAX)) ?
                     PW'(ffha_pkg::HEAP_BYTES_MAX) : PW'(bytes_ff);
   assign init_pay = (total > PW'(h)) ? total - PW'(h) : '0;

   always_comb begin
      rsize = {1'b0, size_ff} + (ffha_pkg::SIZE_W+1)'(7);
      rsize[2:0] = 3'b000;
   end

   assign need      = (PW+2)'(rsize) + (PW+2)'(h) + (PW+2)'(8);
   assign hit_alloc = rd_ff.is_free && ((PW+2)'(rd_ff.payload) >= (PW+2)'(rsize));
   assign rd_addr   = base_ff + ffha_pkg::ADDR_W'(rd_ff.offset) + ffha_pkg::ADDR_W'(h);
   assign hold_addr = base_ff + ffha_pkg::ADDR_W'(hold_ff.offset) + ffha_pkg::ADDR_W'(h);
   assign hit_free  = (rd_addr == rel_ff);

   assign new_off   = ffha_pkg::sat_heap((PW+2)'(hold_ff.offset) + (PW+2)'(h) +
                                         (PW+2)'(rsize));
   assign new_pay_w = (PW+2)'(hold_ff.payload) - (PW+2)'(rsize) - (PW+2)'(h);
   assign idx_m1    = idx_ff - CW'(1);

   always_comb begin
      e_in = rd_ff;
      if (idx_ff == CW'(k_ff)) begin
         e_in.is_free = 1'b1;
      end
   end

   assign join_ok  = pend_ff.is_free && e_in.is_free;
   assign join_pay = ffha_pkg::sat_heap((PW+2)'(pend_ff.payload) + (PW+2)'(h) +
                                        (PW+2)'(e_in.payload));

   assign dp_sts.op         = op_ff;
   assign dp_sts.req_zero   = (size_ff == '0);
   assign dp_sts.scan_end   = (idx_ff == count_ff);
   assign dp_sts.hit        = (op_ff == ffha_pkg::OP_FREE) ? hit_free : hit_alloc;
   assign dp_sts.split_ok   = ((PW+2)'(rd_ff.payload) >= need) &&
                              (count_ff < CW'(ffha_pkg::MAX_BLOCKS));
   assign dp_sts.shift_done = (idx_ff == CW'(k_ff) + CW'(1));

   always_comb begin
      op_in    = op_ff;
      size_in  = size_ff;
      rel_in   = rel_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      w_in     = w_ff;
      hold_in  = hold_ff;
      pend_in  = pend_ff;
      sts_in   = sts_ff;
      addr_in  = addr_ff;
      we       = 1'b0;
      wa       = idx_ff[IW-1:0];
      wd       = rd_ff;
      re       = 1'b0;
      ra       = idx_ff[IW-1:0];
      case (dp_cmd)
         ffha_pkg::CMD_CAPTURE: begin
            op_in   = req_op;
            size_in = req_size;
            rel_in  = req_release_address;
         end
         ffha_pkg::CMD_INIT: begin
            we         = 1'b1;
            wa         = '0;
            wd.offset  = '0;
            wd.payload = init_pay;
            wd.is_free = 1'b1;
            count_in   = CW'(1);
            sts_in     = ffha_pkg::STS_OK;
            addr_in    = '0;
         end
         ffha_pkg::CMD_RES_ZERO: begin
            sts_in  = ffha_pkg::STS_ZERO_SIZE;
            addr_in = '0;
         end
         ffha_pkg::CMD_RES_OK: begin
            sts_in  = ffha_pkg::STS_OK;
            addr_in = '0;
         end
         ffha_pkg::CMD_SCAN_START: begin
            idx_in = '0;
         end
         ffha_pkg::CMD_READ: begin
            re = 1'b1;
         end
         ffha_pkg::CMD_SCAN_NEXT: begin
            idx_in = idx_ff + CW'(1);
         end
         ffha_pkg::CMD_SCAN_MISS: begin
            addr_in = '0;
            if (op_ff == ffha_pkg::OP_FREE) begin
               sts_in = (rel_ff == '0) ? ffha_pkg::STS_OK : ffha_pkg::STS_BAD_ADDR;
            end else begin
               sts_in = ffha_pkg::STS_NO_FIT;
            end
         end
         ffha_pkg::CMD_TAKE_WHOLE: begin
            we         = 1'b1;
            wd.is_free = 1'b0;
            sts_in     = ffha_pkg::STS_OK;
            addr_in    = rd_addr;
         end
         ffha_pkg::CMD_SPLIT_START: begin
            k_in    = idx_ff[IW-1:0];
            hold_in = rd_ff;
            idx_in  = count_ff;
         end
         ffha_pkg::CMD_SHIFT_READ: begin
            re = 1'b1;
            ra = idx_m1[IW-1:0];
         end
         ffha_pkg::CMD_SHIFT_WRITE: begin
            we     = 1'b1;
            idx_in = idx_m1;
         end
         ffha_pkg::CMD_SPLIT_NEW: begin
            we         = 1'b1;
            wa         = k_ff + IW'(1);
            wd.offset  = new_off;
            wd.payload = new_pay_w[PW-1:0];
            wd.is_free = 1'b1;
         end
         ffha_pkg::CMD_SPLIT_OLD: begin
            we         = 1'b1;
            wa         = k_ff;
            wd.offset  = hold_ff.offset;
            wd.payload = rsize[PW-1:0];
            wd.is_free = 1'b0;
            count_in   = count_ff + CW'(1);
            sts_in     = ffha_pkg::STS_OK;
            addr_in    = hold_addr;
         end
         ffha_pkg::CMD_FREE_START: begin
            k_in   = idx_ff[IW-1:0];
            idx_in = '0;
            w_in   = '0;
         end
         ffha_pkg::CMD_MERGE_STEP: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff == '0) begin
               pend_in = e_in;
            end else if (join_ok) begin
               pend_in.payload = join_pay;
            end else begin
               we      = 1'b1;
               wa      = w_ff;
               wd      = pend_ff;
               w_in    = w_ff + IW'(1);
               pend_in = e_in;
            end
         end
         ffha_pkg::CMD_MERGE_END: begin
            we       = 1'b1;
            wa       = w_ff;
            wd       = pend_ff;
            count_in = CW'(w_ff) + CW'(1);
            sts_in   = ffha_pkg::STS_OK;
            addr_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(1);
         idx_ff   <= '0;
         k_ff     <= '0;
         w_ff     <= '0;
         op_ff    <= ffha_pkg::OP_INIT;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         k_ff     <= k_in;
         w_ff     <= w_in;
         op_ff    <= op_in;
      end
      size_ff <= size_in;
      rel_ff  <= rel_in;
      hold_ff <= hold_in;
      pend_ff <= pend_in;
      sts_ff  <= sts_in;
      addr_ff <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

   assign res_status  = sts_ff;
   assign res_address = addr_ff;

endmodule

>>> hw/rtl/first_fit_heap_allocator_core.sv
// An allocate scans the blocks in order and, on a split, moves each later table entry up by one.
// A free scans the blocks for the release address and then runs a merge pass over the whole table.
// One request is handled at a time; the next is taken after the response word leaves.
// Reset restores the configuration registers, then the single free block is written into the table.
// ----------------------------------------------------------------------------
// First-fit heap allocator core
// Stream front end joining the allocator controller and its datapath.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffha_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // op [1:0], req_size [22:2], release_address [54:23], zero fill [55]
   input  logic [55:0]                     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], payload_address [33:2], zero fill [39:34]
   output logic [39:0]                     rsp_tdata
);

   ffha_pkg::dp_cmd_type            dp_cmd;
   ffha_pkg::dp_status_type         dp_sts;
   logic [ffha_pkg::STS_W-1:0]      res_status;
   logic [ffha_pkg::ADDR_W-1:0]     res_address;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .dp_sts    (dp_sts),
      .dp_cmd    (dp_cmd)
   );

   ffha_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_op              (req_tdata[1:0]),
      .req_size            (req_tdata[22:2]),
      .req_release_address (req_tdata[54:23]),
      .dp_cmd              (dp_cmd),
      .dp_sts              (dp_sts),
      .res_status          (res_status),
      .res_address         (res_address)
   );

   assign rsp_tdata = {6'b0, res_address, res_status};

endmodule

>>> hw/rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator port checker
// Checks response ordering and result coding as seen on the core's ports.
// ----------------------------------------------------------------------------
module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped before it was taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response word is pending");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("response word appeared in the cycle after the request");

   a_addr_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != 2'd0) |-> (rsp_tdata[33:2] == 32'd0))
      else $error("nonzero address returned with an error status");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
